// ===== rtl/core/cpu8alu_pkg.sv =====
`timescale 1ns / 1ps

package cpu8alu_pkg;

   localparam int ACTION_W = 5;
   localparam int BYTE_W   = 8;
   localparam int WORD_W   = 16;

   localparam logic [ACTION_W-1:0] ACT_ADD   = 5'd0;
   localparam logic [ACTION_W-1:0] ACT_ADC   = 5'd1;
   localparam logic [ACTION_W-1:0] ACT_SUB   = 5'd2;
   localparam logic [ACTION_W-1:0] ACT_SBC   = 5'd3;
   localparam logic [ACTION_W-1:0] ACT_AND   = 5'd4;
   localparam logic [ACTION_W-1:0] ACT_OR    = 5'd5;
   localparam logic [ACTION_W-1:0] ACT_XOR   = 5'd6;
   localparam logic [ACTION_W-1:0] ACT_CP    = 5'd7;
   localparam logic [ACTION_W-1:0] ACT_INC8  = 5'd8;
   localparam logic [ACTION_W-1:0] ACT_DEC8  = 5'd9;
   localparam logic [ACTION_W-1:0] ACT_INC16 = 5'd10;
   localparam logic [ACTION_W-1:0] ACT_DEC16 = 5'd11;
   localparam logic [ACTION_W-1:0] ACT_ADD16 = 5'd12;
   localparam logic [ACTION_W-1:0] ACT_ADDSP = 5'd13;
   localparam logic [ACTION_W-1:0] ACT_DAA   = 5'd14;
   localparam logic [ACTION_W-1:0] ACT_CPL   = 5'd15;
   localparam logic [ACTION_W-1:0] ACT_CCF   = 5'd16;
   localparam logic [ACTION_W-1:0] ACT_SCF   = 5'd17;
   localparam logic [ACTION_W-1:0] ACT_RLCA  = 5'd18;
   localparam logic [ACTION_W-1:0] ACT_RRCA  = 5'd19;
   localparam logic [ACTION_W-1:0] ACT_RLA   = 5'd20;
   localparam logic [ACTION_W-1:0] ACT_RRA   = 5'd21;

   localparam logic [BYTE_W-1:0] DAA_HI_ADJ   = 8'h60;
   localparam logic [BYTE_W-1:0] DAA_LO_ADJ   = 8'h06;
   localparam logic [BYTE_W-1:0] DAA_HI_LIMIT = 8'h99;
   localparam logic [3:0]        DAA_LO_LIMIT = 4'h9;

   typedef struct packed {
      logic z;
      logic n;
      logic h;
      logic c;
   } flags_type;

endpackage

// ===== rtl/core/cpu8_alu_with_flags_top.sv =====
`timescale 1ns / 1ps

// Accumulator ALU with zero, subtract, half carry and carry flags.
// Each request on the req_ channel carries one action code, a 16-bit operand
// and a 16-bit wide operand (HL or SP). The action runs against the kept
// accumulator and flags, and exactly one response on the rsp_ channel
// returns the new accumulator, a 16-bit data result and the four flags.
// A request is taken when req_valid is high and req_stall is low; a response
// is taken when rsp_valid is high and rsp_stall is low.
// The response is valid in the cycle after the request is taken. Throughput is
// one request per cycle while req_stall is low, set by the single register
// stage that holds the response and the accumulator and flags together.
// The accumulator and flags update when a request is taken, so the next
// request sees them at once.
// While the receiver stalls, the response is held and req_stall is raised
// only if a response is already waiting; a request is taken in the same cycle
// that the waiting response is taken.
// Reset clears the accumulator, the flags and the response valid bit.
module cpu8_alu_with_flags_top (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_stall,
   input  logic [cpu8alu_pkg::ACTION_W-1:0] req_action,
   input  logic [cpu8alu_pkg::WORD_W-1:0]   req_operand,
   input  logic [cpu8alu_pkg::WORD_W-1:0]   req_wide_operand,
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output logic [cpu8alu_pkg::BYTE_W-1:0]   rsp_acc_out,
   output logic [cpu8alu_pkg::WORD_W-1:0]   rsp_data_out,
   output logic                             rsp_zero_flag,
   output logic                             rsp_sub_flag,
   output logic                             rsp_half_carry_flag,
   output logic                             rsp_carry_flag
);
   import cpu8alu_pkg::*;

   logic [BYTE_W-1:0] acc_ff;
   logic [BYTE_W-1:0] acc_in;
   flags_type         flags_ff;
   flags_type         flags_in;
   logic              rsp_valid_ff;
   logic              rsp_valid_in;
   logic [BYTE_W-1:0] rsp_acc_ff;
   logic [WORD_W-1:0] rsp_data_ff;
   logic [WORD_W-1:0] data_in;
   flags_type         rsp_flags_ff;
   logic              req_take;

   logic [BYTE_W-1:0] opb;
   logic              cin_add;
   logic              cin_sub;
   logic [BYTE_W:0]   add_sum;
   logic [4:0]        add_half;
   logic [BYTE_W:0]   sub_diff;
   logic [4:0]        sub_half;
   logic [BYTE_W-1:0] and_res;
   logic [BYTE_W-1:0] or_res;
   logic [BYTE_W-1:0] xor_res;
   logic [BYTE_W-1:0] inc8_res;
   logic [BYTE_W-1:0] dec8_res;
   logic [WORD_W:0]   add16_sum;
   logic [12:0]       add16_half;
   logic [WORD_W-1:0] addsp_res;
   logic [BYTE_W:0]   addsp_low;
   logic [4:0]        addsp_half;
   logic              daa_hi;
   logic              daa_lo;
   logic [BYTE_W-1:0] daa_adj;
   logic [BYTE_W-1:0] daa_res;
   logic              daa_c;

   assign req_take     = req_valid && !req_stall;
   assign req_stall    = rsp_valid_ff && rsp_stall;
   assign rsp_valid_in = req_take || (rsp_valid_ff && rsp_stall);

   assign opb     = req_operand[BYTE_W-1:0];
   assign cin_add = (req_action == ACT_ADC) && flags_ff.c;
   assign cin_sub = (req_action == ACT_SBC) && flags_ff.c;

   assign add_sum  = {1'b0, acc_ff} + {1'b0, opb} + {{BYTE_W{1'b0}}, cin_add};
   assign add_half = {1'b0, acc_ff[3:0]} + {1'b0, opb[3:0]} + {4'd0, cin_add};
   assign sub_diff = {1'b0, acc_ff} - {1'b0, opb} - {{BYTE_W{1'b0}}, cin_sub};
   assign sub_half = {1'b0, acc_ff[3:0]} - {1'b0, opb[3:0]} - {4'd0, cin_sub};

   assign and_res = acc_ff & opb;
   assign or_res  = acc_ff | opb;
   assign xor_res = acc_ff ^ opb;

   assign inc8_res = opb + 8'd1;
   assign dec8_res = opb - 8'd1;

   assign add16_sum  = {1'b0, req_wide_operand} + {1'b0, req_operand};
   assign add16_half = {1'b0, req_wide_operand[11:0]} + {1'b0, req_operand[11:0]};

   assign addsp_res  = req_wide_operand + {{BYTE_W{opb[BYTE_W-1]}}, opb};
   assign addsp_low  = {1'b0, req_wide_operand[BYTE_W-1:0]} + {1'b0, opb};
   assign addsp_half = {1'b0, req_wide_operand[3:0]} + {1'b0, opb[3:0]};

   assign daa_hi  = flags_ff.c || (acc_ff > DAA_HI_LIMIT);
   assign daa_lo  = flags_ff.h || (acc_ff[3:0] > DAA_LO_LIMIT);

   always_comb begin
      if (flags_ff.n) begin
         daa_adj = (flags_ff.c ? DAA_HI_ADJ : 8'd0) | (flags_ff.h ? DAA_LO_ADJ : 8'd0);
         daa_res = acc_ff - daa_adj;
         daa_c   = flags_ff.c;
      end else begin
         daa_adj = (daa_hi ? DAA_HI_ADJ : 8'd0) | (daa_lo ? DAA_LO_ADJ : 8'd0);
         daa_res = acc_ff + daa_adj;
         daa_c   = daa_hi;
      end
   end

   always_comb begin
      acc_in   = acc_ff;
      flags_in = flags_ff;
      data_in  = '0;
      unique case (req_action) inside
         ACT_ADD, ACT_ADC: begin
            acc_in   = add_sum[BYTE_W-1:0];
            flags_in = '{z: (add_sum[BYTE_W-1:0] == 8'd0), n: 1'b0,
                         h: add_half[4], c: add_sum[BYTE_W]};
         end
         ACT_SUB, ACT_SBC, ACT_CP: begin
            if (req_action != ACT_CP) begin
               acc_in = sub_diff[BYTE_W-1:0];
            end
            flags_in = '{z: (sub_diff[BYTE_W-1:0] == 8'd0), n: 1'b1,
                         h: sub_half[4], c: sub_diff[BYTE_W]};
         end
         ACT_AND: begin
            acc_in   = and_res;
            flags_in = '{z: (and_res == 8'd0), n: 1'b0, h: 1'b1, c: 1'b0};
         end
         ACT_OR: begin
            acc_in   = or_res;
            flags_in = '{z: (or_res == 8'd0), n: 1'b0, h: 1'b0, c: 1'b0};
         end
         ACT_XOR: begin
            acc_in   = xor_res;
            flags_in = '{z: (xor_res == 8'd0), n: 1'b0, h: 1'b0, c: 1'b0};
         end
         ACT_INC8: begin
            data_in  = {{BYTE_W{1'b0}}, inc8_res};
            flags_in = '{z: (inc8_res == 8'd0), n: 1'b0,
                         h: (opb[3:0] == 4'hF), c: flags_ff.c};
         end
         ACT_DEC8: begin
            data_in  = {{BYTE_W{1'b0}}, dec8_res};
            flags_in = '{z: (dec8_res == 8'd0), n: 1'b1,
                         h: (opb[3:0] == 4'h0), c: flags_ff.c};
         end
         ACT_INC16: begin
            data_in = req_operand + 16'd1;
         end
         ACT_DEC16: begin
            data_in = req_operand - 16'd1;
         end
         ACT_ADD16: begin
            data_in  = add16_sum[WORD_W-1:0];
            flags_in = '{z: flags_ff.z, n: 1'b0, h: add16_half[12], c: add16_sum[WORD_W]};
         end
         ACT_ADDSP: begin
            data_in  = addsp_res;
            flags_in = '{z: 1'b0, n: 1'b0, h: addsp_half[4], c: addsp_low[BYTE_W]};
         end
         ACT_DAA: begin
            acc_in   = daa_res;
            flags_in = '{z: (daa_res == 8'd0), n: flags_ff.n, h: 1'b0, c: daa_c};
         end
         ACT_CPL: begin
            acc_in   = ~acc_ff;
            flags_in = '{z: flags_ff.z, n: 1'b1, h: 1'b1, c: flags_ff.c};
         end
         ACT_CCF: begin
            flags_in = '{z: flags_ff.z, n: 1'b0, h: 1'b0, c: !flags_ff.c};
         end
         ACT_SCF: begin
            flags_in = '{z: flags_ff.z, n: 1'b0, h: 1'b0, c: 1'b1};
         end
         ACT_RLCA: begin
            acc_in   = {acc_ff[BYTE_W-2:0], acc_ff[BYTE_W-1]};
            flags_in = '{z: 1'b0, n: 1'b0, h: 1'b0, c: acc_ff[BYTE_W-1]};
         end
         ACT_RRCA: begin
            acc_in   = {acc_ff[0], acc_ff[BYTE_W-1:1]};
            flags_in = '{z: 1'b0, n: 1'b0, h: 1'b0, c: acc_ff[0]};
         end
         ACT_RLA: begin
            acc_in   = {acc_ff[BYTE_W-2:0], flags_ff.c};
            flags_in = '{z: 1'b0, n: 1'b0, h: 1'b0, c: acc_ff[BYTE_W-1]};
         end
         ACT_RRA: begin
            acc_in   = {flags_ff.c, acc_ff[BYTE_W-1:1]};
            flags_in = '{z: 1'b0, n: 1'b0, h: 1'b0, c: acc_ff[0]};
         end
         default: begin
            acc_in   = acc_ff;
            flags_in = flags_ff;
            data_in  = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff       <= '0;
         flags_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (req_take) begin
            acc_ff   <= acc_in;
            flags_ff <= flags_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         rsp_acc_ff   <= acc_in;
         rsp_data_ff  <= data_in;
         rsp_flags_ff <= flags_in;
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_acc_out         = rsp_acc_ff;
   assign rsp_data_out        = rsp_data_ff;
   assign rsp_zero_flag       = rsp_flags_ff.z;
   assign rsp_sub_flag        = rsp_flags_ff.n;
   assign rsp_half_carry_flag = rsp_flags_ff.h;
   assign rsp_carry_flag      = rsp_flags_ff.c;

   a_reset_clears_valid: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid after reset");

   a_take_gives_response: assert property (@(posedge clock) disable iff (reset)
      req_take |=> rsp_valid)
      else $error("taken request gave no response");

   a_compare_keeps_acc: assert property (@(posedge clock) disable iff (reset)
      (req_take && req_action == ACT_CP) |=> (acc_ff == $past(acc_ff)))
      else $error("compare changed the accumulator");

   a_response_matches_state: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_acc_out == acc_ff && rsp_flags_ff == flags_ff))
      else $error("response disagrees with kept accumulator or flags");

endmodule

// ===== bench/cpu8_alu_with_flags_top_tb.sv =====
`timescale 1ns / 1ps

module cpu8_alu_with_flags_top_tb;
   import cpu8alu_pkg::*;

   localparam logic [ACTION_W-1:0] ACT_FIRST_UNUSED = 5'd22;
   localparam logic [ACTION_W-1:0] ACT_LAST_CODE    = 5'd31;

   typedef struct packed {
      logic [BYTE_W-1:0] acc;
      logic [WORD_W-1:0] data;
      flags_type         flg;
   } alu_result_type;

   class alu_flag_tracker;
      logic [BYTE_W-1:0] acc_q = '0;
      flags_type         flags_q = '0;
      alu_result_type    pending_results[$];
      int unsigned       requests = 0;
      int unsigned       responses = 0;
      int unsigned       mismatches = 0;

      function int pending();
         return pending_results.size();
      endfunction

      function void apply_action(logic [ACTION_W-1:0] action, logic [WORD_W-1:0] operand,
                                 logic [WORD_W-1:0] wide);
         logic [BYTE_W-1:0] a;
         logic [BYTE_W-1:0] b;
         logic [BYTE_W-1:0] step8;
         flags_type         f;
         logic              cin;
         logic [8:0]        sum9;
         logic [4:0]        nib;
         logic [12:0]       sum13;
         logic [16:0]       sum17;
         logic [WORD_W-1:0] data;
         alu_result_type    res;
         a = acc_q;
         f = flags_q;
         b = operand[7:0];
         cin = f.c;
         data = '0;
         case (action)
            ACT_ADD, ACT_ADC: begin
               if (action == ACT_ADD) cin = 1'b0;
               sum9 = {1'b0, a} + {1'b0, b} + cin;
               nib = {1'b0, a[3:0]} + {1'b0, b[3:0]} + cin;
               a = sum9[7:0];
               f.z = (a == 8'h00);
               f.n = 1'b0;
               f.h = nib[4];
               f.c = sum9[8];
            end
            ACT_SUB, ACT_SBC, ACT_CP: begin
               if (action != ACT_SBC) cin = 1'b0;
               sum9 = {1'b0, a} - {1'b0, b} - cin;
               nib = {1'b0, a[3:0]} - {1'b0, b[3:0]} - cin;
               f.z = (sum9[7:0] == 8'h00);
               f.n = 1'b1;
               f.h = nib[4];
               f.c = sum9[8];
               if (action != ACT_CP) a = sum9[7:0];
            end
            ACT_AND: begin
               a = a & b;
               f.z = (a == 8'h00);
               f.n = 1'b0;
               f.h = 1'b1;
               f.c = 1'b0;
            end
            ACT_OR, ACT_XOR: begin
               a = (action == ACT_OR) ? (a | b) : (a ^ b);
               f.z = (a == 8'h00);
               f.n = 1'b0;
               f.h = 1'b0;
               f.c = 1'b0;
            end
            ACT_INC8: begin
               step8 = b + 8'd1;
               data = {8'h00, step8};
               f.z = (step8 == 8'h00);
               f.n = 1'b0;
               f.h = (b[3:0] == 4'hF);
            end
            ACT_DEC8: begin
               step8 = b - 8'd1;
               data = {8'h00, step8};
               f.z = (step8 == 8'h00);
               f.n = 1'b1;
               f.h = (b[3:0] == 4'h0);
            end
            ACT_INC16: data = operand + 16'd1;
            ACT_DEC16: data = operand - 16'd1;
            ACT_ADD16: begin
               sum17 = {1'b0, wide} + {1'b0, operand};
               sum13 = {1'b0, wide[11:0]} + {1'b0, operand[11:0]};
               data = sum17[15:0];
               f.n = 1'b0;
               f.h = sum13[12];
               f.c = sum17[16];
            end
            ACT_ADDSP: begin
               data = wide + {{8{b[7]}}, b};
               nib = {1'b0, wide[3:0]} + {1'b0, b[3:0]};
               sum9 = {1'b0, wide[7:0]} + {1'b0, b};
               f.z = 1'b0;
               f.n = 1'b0;
               f.h = nib[4];
               f.c = sum9[8];
            end
            ACT_DAA: begin
               if (f.n) begin
                  if (f.c) a = a - DAA_HI_ADJ;
                  if (f.h) a = a - DAA_LO_ADJ;
               end else begin
                  if (f.c || a > DAA_HI_LIMIT) begin
                     a = a + DAA_HI_ADJ;
                     f.c = 1'b1;
                  end
                  if (f.h || a[3:0] > DAA_LO_LIMIT) a = a + DAA_LO_ADJ;
               end
               f.h = 1'b0;
               f.z = (a == 8'h00);
            end
            ACT_CPL: begin
               a = ~a;
               f.n = 1'b1;
               f.h = 1'b1;
            end
            ACT_CCF, ACT_SCF: begin
               f.n = 1'b0;
               f.h = 1'b0;
               f.c = (action == ACT_SCF) ? 1'b1 : ~f.c;
            end
            ACT_RLCA, ACT_RRCA, ACT_RLA, ACT_RRA: begin
               f.z = 1'b0;
               f.n = 1'b0;
               f.h = 1'b0;
               case (action)
                  ACT_RLCA: begin
                     f.c = a[7];
                     a = {a[6:0], a[7]};
                  end
                  ACT_RRCA: begin
                     f.c = a[0];
                     a = {a[0], a[7:1]};
                  end
                  ACT_RLA: begin
                     f.c = a[7];
                     a = {a[6:0], cin};
                  end
                  default: begin
                     f.c = a[0];
                     a = {cin, a[7:1]};
                  end
               endcase
            end
            default: ;
         endcase
         acc_q = a;
         flags_q = f;
         res.acc = a;
         res.data = data;
         res.flg = f;
         pending_results.push_back(res);
         requests++;
      endfunction

      function void compare_response(logic [BYTE_W-1:0] acc, logic [WORD_W-1:0] data,
                                     logic z, logic n, logic h, logic c);
         alu_result_type want;
         if (pending_results.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("mismatch: response acc %02h data %04h with no request waiting",
                        acc, data);
            return;
         end
         want = pending_results.pop_front();
         responses++;
         if (want.acc !== acc || want.data !== data || want.flg.z !== z || want.flg.n !== n ||
             want.flg.h !== h || want.flg.c !== c) begin
            mismatches++;
            if (mismatches <= 10) begin
               $write("mismatch on response %0d: expected acc %02h data %04h znhc %b%b%b%b,",
                      responses, want.acc, want.data, want.flg.z, want.flg.n, want.flg.h,
                      want.flg.c);
               $display(" got acc %02h data %04h znhc %b%b%b%b", acc, data, z, n, h, c);
            end
         end
      endfunction
   endclass

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_valid = 1'b0;
   logic                req_stall;
   logic [ACTION_W-1:0] req_action = '0;
   logic [WORD_W-1:0]   req_operand = '0;
   logic [WORD_W-1:0]   req_wide_operand = '0;
   logic                rsp_valid;
   logic                rsp_stall = 1'b0;
   logic [BYTE_W-1:0]   rsp_acc_out;
   logic [WORD_W-1:0]   rsp_data_out;
   logic                rsp_zero_flag;
   logic                rsp_sub_flag;
   logic                rsp_half_carry_flag;
   logic                rsp_carry_flag;

   int              send_idle_pct = 0;
   int              recv_idle_pct = 0;
   int unsigned     bcd_sequences = 0;
   alu_flag_tracker board = new;

   cpu8_alu_with_flags_top dut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_action          (req_action),
      .req_operand         (req_operand),
      .req_wide_operand    (req_wide_operand),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_acc_out         (rsp_acc_out),
      .rsp_data_out        (rsp_data_out),
      .rsp_zero_flag       (rsp_zero_flag),
      .rsp_sub_flag        (rsp_sub_flag),
      .rsp_half_carry_flag (rsp_half_carry_flag),
      .rsp_carry_flag      (rsp_carry_flag)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   always @(posedge clock) begin
      rsp_stall <= ($urandom_range(99, 0) < recv_idle_pct);
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && !rsp_stall)
            board.compare_response(rsp_acc_out, rsp_data_out, rsp_zero_flag, rsp_sub_flag,
                                   rsp_half_carry_flag, rsp_carry_flag);
         if (req_valid && !req_stall)
            board.apply_action(req_action, req_operand, req_wide_operand);
      end
   end

   task automatic send_request(input logic [ACTION_W-1:0] action,
                               input logic [WORD_W-1:0] operand,
                               input logic [WORD_W-1:0] wide);
      if ($urandom_range(99, 0) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
         while ($urandom_range(99, 0) < send_idle_pct) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_action <= action;
      req_operand <= operand;
      req_wide_operand <= wide;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   task automatic wait_for_results();
      req_valid <= 1'b0;
      @(posedge clock);
      while (board.pending() != 0) @(posedge clock);
   endtask

   function automatic logic [WORD_W-1:0] pick_word();
      case ($urandom_range(5, 0))
         0: return 16'h0000;
         1: return 16'hFFFF;
         2: return {8'($urandom), 8'h80};
         3: return {8'($urandom), 8'h0F};
         default: return 16'($urandom);
      endcase
   endfunction

   task automatic random_requests(input int count);
      int                  sent;
      logic [BYTE_W-1:0]   bcd_a;
      logic [BYTE_W-1:0]   bcd_b;
      logic [ACTION_W-1:0] action;
      sent = 0;
      while (sent < count) begin
         if ($urandom_range(99, 0) < 20) begin
            bcd_a = {4'($urandom_range(9, 0)), 4'($urandom_range(9, 0))};
            bcd_b = {4'($urandom_range(9, 0)), 4'($urandom_range(9, 0))};
            action = 5'($urandom_range(int'(ACT_SBC), int'(ACT_ADD)));
            send_request(ACT_AND, {8'($urandom), 8'h00}, 16'($urandom));
            send_request(ACT_OR, {8'($urandom), bcd_a}, 16'($urandom));
            if ($urandom_range(1, 0) == 1) begin
               send_request(ACT_SCF, 16'($urandom), 16'($urandom));
               sent++;
            end
            send_request(action, {8'($urandom), bcd_b}, 16'($urandom));
            send_request(ACT_DAA, 16'($urandom), 16'($urandom));
            sent += 4;
            bcd_sequences++;
         end else begin
            if ($urandom_range(19, 0) == 0)
               action = 5'($urandom_range(int'(ACT_LAST_CODE), int'(ACT_FIRST_UNUSED)));
            else
               action = 5'($urandom_range(int'(ACT_RRA), int'(ACT_ADD)));
            send_request(action, pick_word(), pick_word());
            sent++;
         end
      end
   endtask

   initial begin
      #2_000_000;
      $display("FAIL cpu8_alu_with_flags_top");
      $finish;
   end

   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      send_idle_pct = 38;
      recv_idle_pct = 63;

      send_request(ACT_ADD, 16'hFFFF, 16'h0000);
      send_request(ACT_ADC, 16'h0001, 16'hFFFF);
      send_request(ACT_SUB, 16'h0001, 16'h0000);
      send_request(ACT_SBC, 16'hFF00, 16'hFFFF);
      send_request(ACT_AND, 16'h00FF, 16'h0000);
      send_request(ACT_OR, 16'h8000, 16'hFFFF);
      send_request(ACT_XOR, 16'h00FE, 16'h0000);
      send_request(ACT_CP, 16'h0080, 16'hFFFF);
      send_request(ACT_INC8, 16'hAAFF, 16'h0000);
      send_request(ACT_DEC8, 16'h5500, 16'hFFFF);
      send_request(ACT_INC16, 16'hFFFF, 16'h0000);
      send_request(ACT_DEC16, 16'h0000, 16'hFFFF);
      send_request(ACT_ADD16, 16'h0001, 16'hFFFF);
      send_request(ACT_ADDSP, 16'h0080, 16'h0000);
      send_request(ACT_ADD, 16'h00A9, 16'h0000);
      send_request(ACT_DAA, 16'h0000, 16'h0000);
      send_request(ACT_CPL, 16'hFFFF, 16'hFFFF);
      send_request(ACT_CCF, 16'h0000, 16'h0000);
      send_request(ACT_SCF, 16'hFFFF, 16'hFFFF);
      send_request(ACT_RLCA, 16'h0000, 16'h0000);
      send_request(ACT_RRCA, 16'hFFFF, 16'hFFFF);
      send_request(ACT_RLA, 16'h0000, 16'h0000);
      send_request(ACT_RRA, 16'hFFFF, 16'hFFFF);
      send_request(ACT_FIRST_UNUSED, 16'hFFFF, 16'hFFFF);
      send_request(ACT_LAST_CODE, 16'h0000, 16'h0000);

      random_requests(575);
      wait_for_results();
      send_idle_pct = 63;
      recv_idle_pct = 38;
      random_requests(575);
      wait_for_results();
      send_idle_pct = 0;
      recv_idle_pct = 0;
      random_requests(575);
      wait_for_results();
      repeat (4) @(posedge clock);

      $display("Ran %0d requests and checked %0d responses over every action and unused codes,",
               board.requests, board.responses);
      $display("including %0d BCD add or subtract sequences with decimal adjust; mismatches: %0d.",
               bcd_sequences, board.mismatches);
      if (board.mismatches == 0 && board.pending() == 0)
         $display("PASS cpu8_alu_with_flags_top");
      else
         $display("FAIL cpu8_alu_with_flags_top");
      $finish;
   end

endmodule
